### sv/bpb_pkg.sv
package bpb_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DIGIT_COUNT   = 2'd0;
  localparam cfg_idx_t CFG_MIN_BYTES     = 2'd1;
  localparam cfg_idx_t CFG_SIGNED_MODE   = 2'd2;
  localparam cfg_idx_t CFG_LITTLE_ENDIAN = 2'd3;

  // Register reset values
  localparam logic [4:0] DIGIT_COUNT_RST = 5'd16;
  localparam logic [4:0] MIN_BYTES_RST   = 5'd0;

  // Sign mark ORed into the most significant byte of a negative field
  localparam logic [7:0] SIGN_MARK = 8'hF0;

  // Per-transaction controls handed from the front part to the back part
  typedef struct packed {
    logic [4:0] digit_count;
    logic       little_endian;
    logic       negative;
  } bpb_ctl_t;

endpackage

### sv/bpb_front.sv
module bpb_front #(
  parameter int MAX_BYTES  = 16,
  parameter int VALUE_BITS = 64,
  parameter int LEN_W      = $clog2(MAX_BYTES + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  bpb_pkg::cfg_idx_t                     cfg_index,
  input  logic [bpb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [VALUE_BITS-1:0]          value,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [VALUE_BITS-1:0]                 q_mag,
  output logic [LEN_W-1:0]                      q_len,
  output bpb_pkg::bpb_ctl_t                     q_ctl
);
  import bpb_pkg::*;

  logic [4:0] digit_count;
  logic [4:0] min_bytes;
  logic       signed_mode;
  logic       little_endian;

  logic [VALUE_BITS-1:0] raw;
  logic                  negative;
  logic [5:0]            base_len;
  logic [5:0]            field_len;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= DIGIT_COUNT_RST;
      min_bytes     <= MIN_BYTES_RST;
      signed_mode   <= 1'b0;
      little_endian <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIGIT_COUNT:   digit_count   <= cfg_data;
        CFG_MIN_BYTES:     min_bytes     <= cfg_data;
        CFG_SIGNED_MODE:   signed_mode   <= cfg_data[0];
        CFG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
      endcase
    end
  end

  // Classify: sign, magnitude and field length
  always_comb begin
    raw      = value;
    negative = signed_mode & raw[VALUE_BITS-1];
    q_mag    = negative ? (~raw + 1'b1) : raw;

    base_len = ({1'b0, digit_count} + (signed_mode ? 6'd2 : 6'd1)) >> 1;
    field_len = ({1'b0, min_bytes} > base_len) ? {1'b0, min_bytes} : base_len;
    if (field_len > 6'(MAX_BYTES)) begin
      field_len = 6'(MAX_BYTES);
    end
    q_len = LEN_W'(field_len);

    q_ctl.digit_count   = digit_count;
    q_ctl.little_endian = little_endian;
    q_ctl.negative      = negative;
  end

  // Hold the input while the queue is full; drop empty fields
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full & (field_len != 6'd0);

endmodule

### sv/bpb_queue.sv
module bpb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign pop_data = entry[rd_ptr];
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);

endmodule

### sv/bpb_back.sv
module bpb_back #(
  parameter int MAX_BYTES  = 16,
  parameter int VALUE_BITS = 64,
  parameter int LEN_W      = $clog2(MAX_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [VALUE_BITS-1:0] q_mag,
  input  logic [LEN_W-1:0]      q_len,
  input  bpb_pkg::bpb_ctl_t     q_ctl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  last
);
  import bpb_pkg::*;

  localparam int NDIG  = VALUE_BITS / 3 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int IDX_W = $clog2(MAX_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CONVERT = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] bin;
  logic [NDIG*4-1:0]     bcd;
  logic [NDIG*4-1:0]     bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      pos;
  bpb_ctl_t              ctl;

  logic [3:0]            digit [2*MAX_BYTES];
  logic [7:0]            field [MAX_BYTES];
  logic [LEN_W-1:0]      sel;
  logic                  sel_last;
  logic                  out_load;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? bcd[d*4 +: 4] + 4'd3 : bcd[d*4 +: 4];
    end
  end

  // Mask digits above the digit count and pack two per byte
  always_comb begin
    for (int d = 0; d < 2*MAX_BYTES; d++) begin
      digit[d] = 4'd0;
    end
    for (int d = 0; d < NDIG && d < 2*MAX_BYTES; d++) begin
      if (d < int'(ctl.digit_count)) begin
        digit[d] = bcd[d*4 +: 4];
      end
    end
    for (int b = 0; b < MAX_BYTES; b++) begin
      field[b] = {digit[2*b+1], digit[2*b]};
    end
  end

  // Pick the byte for this output position
  assign sel_last = (pos == len - 1'b1);
  assign sel      = ctl.little_endian ? pos : (len - 1'b1 - pos);
  assign out_load = (state == ST_EMIT) & (~out_valid | ~out_stall);
  assign q_pop    = (state == ST_IDLE) & ~q_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && sel_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load, shift one bit per cycle, then step through the bytes
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        bin <= q_mag;
        bcd <= '0;
        cnt <= '0;
        len <= q_len;
        ctl <= q_ctl;
        pos <= '0;
      end
      ST_CONVERT: begin
        bcd <= {bcd_adj[NDIG*4-2:0], bin[VALUE_BITS-1]};
        bin <= {bin[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ST_EMIT: begin
        if (out_load) begin
          pos <= pos + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= field[sel[IDX_W-1:0]] | ((ctl.negative && sel == len - 1'b1) ? SIGN_MARK : 8'd0);
      last     <= sel_last;
    end
  end

endmodule

### sv/binary_to_packed_bcd_bytes.sv
// Binary to packed BCD byte stream.
// Each value is converted one bit per cycle through the shift-and-add-3 converter, then
// its bytes are emitted one byte per cycle while out_stall is low. The back end finishes
// one value before it pops another from the queue; a two-entry queue lets
// the input side run ahead. Empty fields produce no output.
// Reset: rst (synchronous) clears the queue and control, restores register defaults.
module binary_to_packed_bcd_bytes #(
  parameter int MAX_BYTES  = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  bpb_pkg::cfg_idx_t              cfg_index,
  input  logic [bpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VALUE_BITS-1:0]   value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           last
);
  import bpb_pkg::*;

  localparam int LEN_W = $clog2(MAX_BYTES + 1);
  localparam int Q_W   = VALUE_BITS + LEN_W + $bits(bpb_ctl_t);

  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] f_mag;
  logic [LEN_W-1:0]      f_len;
  bpb_ctl_t              f_ctl;
  logic [VALUE_BITS-1:0] b_mag;
  logic [LEN_W-1:0]      b_len;
  bpb_ctl_t              b_ctl;
  logic [Q_W-1:0]        q_out;

  bpb_front #(
    .MAX_BYTES  (MAX_BYTES),
    .VALUE_BITS (VALUE_BITS),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_mag     (f_mag),
    .q_len     (f_len),
    .q_ctl     (f_ctl)
  );

  bpb_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_mag, f_len, f_ctl}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {b_mag, b_len, b_ctl} = q_out;

  bpb_back #(
    .MAX_BYTES  (MAX_BYTES),
    .VALUE_BITS (VALUE_BITS),
    .LEN_W      (LEN_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_mag     (b_mag),
    .q_len     (b_len),
    .q_ctl     (b_ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
